>>> design/proxy_v2_header_parser_defines.svh
// Assertion macros for the PROXY v2 header parser.
`ifndef PROXY_V2_HEADER_PARSER_DEFINES_SVH
`define PROXY_V2_HEADER_PARSER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define PHV2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PHV2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/phv2_pkg.sv
// Types, codes and helper functions shared by the PROXY header parser.
`timescale 1ns / 1ps
package phv2_pkg;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  family;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] tlv_length;
    logic [16:0] header_length;
  } out_item_t;

  // status codes
  localparam logic [3:0] ST_PROXIED  = 4'd0;
  localparam logic [3:0] ST_LOCAL    = 4'd1;
  localparam logic [3:0] ST_IGNORED  = 4'd2;
  localparam logic [3:0] ST_V1_DONE  = 4'd3;
  localparam logic [3:0] ST_JUNK     = 4'd4;
  localparam logic [3:0] ST_OVERFLOW = 4'd5;
  localparam logic [3:0] ST_BAD_VER  = 4'd6;
  localparam logic [3:0] ST_BAD_CMD  = 4'd7;
  localparam logic [3:0] ST_DRIBBLE  = 4'd8;
  localparam logic [3:0] ST_LEN_ERR  = 4'd9;
  localparam logic [3:0] ST_CRC_ERR  = 4'd10;

  // TLV walker step results
  localparam logic [2:0] WK_NONE    = 3'd0;
  localparam logic [2:0] WK_DRIBBLE = 3'd1;
  localparam logic [2:0] WK_LENGTH  = 3'd2;
  localparam logic [2:0] WK_HDR     = 3'd3;
  localparam logic [2:0] WK_VAL     = 3'd4;

  // TLV walk error
  localparam logic [1:0] TE_NONE    = 2'd0;
  localparam logic [1:0] TE_DRIBBLE = 2'd1;
  localparam logic [1:0] TE_LENGTH  = 2'd2;

  // outer TLV kind
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_SSL   = 2'd1;
  localparam logic [1:0] KIND_CRC   = 2'd2;

  // parse phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_MAX_PAYLOAD = 8'd0;
  localparam logic [7:0] REG_V1_LIMIT    = 8'd1;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
  localparam logic [9:0]  V1_LIMIT_RST    = 10'd107;
  localparam logic [31:0] CRC_INIT        = 32'hffffffff;
  localparam logic [31:0] CRC_POLY        = 32'h82F63B78;
  localparam logic [7:0]  FP_TCP4         = 8'h11;
  localparam logic [7:0]  FP_TCP6         = 8'h21;
  localparam logic [7:0]  TLV_TYPE_SSL    = 8'h20;
  localparam logic [7:0]  TLV_TYPE_CRC    = 8'h03;
  localparam logic [16:0] IDX_MAX         = 17'h1ffff;

  typedef struct packed {
    logic [2:0]  res;
    logic [7:0]  hdr_type;
    logic [15:0] hdr_len;
    logic [15:0] vidx;
  } walk_out_t;

  function automatic logic [7:0] sig1_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h52;
      3'd2:    r = 8'h4f;
      3'd3:    r = 8'h58;
      default: r = 8'h59;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sig2_byte(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0, 4'd2, 4'd5: r = 8'h0d;
      4'd1, 4'd3, 4'd6: r = 8'h0a;
      4'd4:             r = 8'h00;
      4'd7:             r = 8'h51;
      4'd8:             r = 8'h55;
      4'd9:             r = 8'h49;
      4'd10:            r = 8'h54;
      default:          r = 8'h0a;
    endcase
    return r;
  endfunction

  // CRC32C, reflected, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> design/phv2_tlv_walk.sv
// TLV walker: tracks type, length and value position inside one TLV region.
`timescale 1ns / 1ps
module phv2_tlv_walk
  import phv2_pkg::*;
(
  input  logic        clk,
  input  logic        init,
  input  logic [15:0] init_len,
  input  logic        step,
  input  logic [7:0]  data,
  output walk_out_t   wo
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] avail_r, avail_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] vpos_r, vpos_nxt;
  logic [15:0] tl;

  always_comb begin
    rem_nxt     = rem_r;
    avail_nxt   = avail_r;
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    tlen_nxt    = tlen_r;
    vpos_nxt    = vpos_r;
    tl          = {tlen_r[15:8], data};
    wo.res      = WK_NONE;
    wo.hdr_type = type_r;
    wo.hdr_len  = tl;
    wo.vidx     = vpos_r;
    if (init) begin
      rem_nxt   = init_len;
      avail_nxt = '0;
      pos_nxt   = '0;
      type_nxt  = '0;
      tlen_nxt  = '0;
      vpos_nxt  = '0;
    end else if (step && rem_r != 16'd0) begin
      unique case (pos_r)
        2'd0: begin
          if (rem_r < 16'd3) begin
            wo.res = WK_DRIBBLE;
          end else begin
            avail_nxt = rem_r;
            type_nxt  = data;
            pos_nxt   = 2'd1;
            rem_nxt   = rem_r - 16'd1;
          end
        end
        2'd1: begin
          tlen_nxt = {data, 8'd0};
          pos_nxt  = 2'd2;
          rem_nxt  = rem_r - 16'd1;
        end
        2'd2: begin
          tlen_nxt = tl;
          if ({1'b0, tl} + 17'd3 > {1'b0, avail_r}) begin
            wo.res = WK_LENGTH;
          end else begin
            vpos_nxt = '0;
            pos_nxt  = (tl != 16'd0) ? 2'd3 : 2'd0;
            rem_nxt  = rem_r - 16'd1;
            wo.res   = WK_HDR;
          end
        end
        default: begin
          vpos_nxt = vpos_r + 16'd1;
          if (vpos_nxt >= tlen_r) pos_nxt = 2'd0;
          rem_nxt = rem_r - 16'd1;
          wo.res  = WK_VAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    avail_r <= avail_nxt;
    pos_r   <= pos_nxt;
    type_r  <= type_nxt;
    tlen_r  <= tlen_nxt;
    vpos_r  <= vpos_nxt;
  end

endmodule

>>> design/proxy_v2_header_parser.sv
// Top level of the PROXY protocol header parser.
// Takes one byte per transaction and accepts a new byte every cycle while no
// untaken result stalls it. A byte waits in the input register while the parse
// logic works on it, and any result lands in the output register at the edge
// that consumes the deciding byte. A result the receiver
// has not taken stalls the input register, and with it the input channel. The
// sustained rate of one byte per cycle is set by the combinational state update
// (signature match, CRC32C byte step and the two TLV walkers). At most one
// result per header; a byte with first_byte set restarts parsing.
// Configuration writes are taken at any time, one per cycle.
`timescale 1ns / 1ps
module proxy_v2_header_parser
  import phv2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
`include "proxy_v2_header_parser_defines.svh"

  logic        in_valid_r, in_valid_nxt;
  in_item_t    in_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;
  logic        advance, process;

  logic [15:0] max_payload_r;
  logic [9:0]  v1_limit_r;

  logic [1:0]   phase_r, phase_nxt;
  logic [16:0]  idx_r, idx_nxt;
  logic [1:0]   sig_r, sig_nxt;
  logic [7:0]   vc_r, vc_nxt;
  logic [7:0]   fp_r, fp_nxt;
  logic [15:0]  pl_r, pl_nxt;
  logic [127:0] src_r, src_nxt;
  logic [127:0] dst_r, dst_nxt;
  logic [15:0]  sport_r, sport_nxt;
  logic [15:0]  dport_r, dport_nxt;
  logic [31:0]  crc_r, crc_nxt;
  logic [31:0]  exp_r, exp_nxt;
  logic         seen_r, seen_nxt;
  logic [1:0]   terr_r, terr_nxt;
  logic [1:0]   kind_r, kind_nxt;

  logic        clr, emit, full;
  logic [3:0]  st;
  logic [16:0] hlen, z, off;
  logic [7:0]  b, cb;
  logic [1:0]  fam;
  logic [4:0]  alen;
  logic [5:0]  flen;
  logic        o_init, o_step, i_init, i_step;
  logic [15:0] o_len, i_len;
  walk_out_t   o_wo, i_wo;

  assign advance   = !out_valid_r || out_ready;
  assign process   = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  phv2_tlv_walk u_outer (
    .clk(clk), .init(o_init), .init_len(o_len), .step(o_step), .data(b), .wo(o_wo)
  );
  phv2_tlv_walk u_inner (
    .clk(clk), .init(i_init), .init_len(i_len), .step(i_step), .data(b), .wo(i_wo)
  );

  always_comb begin
    clr = process && in_r.first_byte;
    b   = in_r.data_byte;
    cb  = b;
    // start from cleared state on the first byte of a connection
    z         = clr ? 17'd0 : idx_r;
    sig_nxt   = clr ? 2'd3 : sig_r;
    vc_nxt    = clr ? 8'd0 : vc_r;
    fp_nxt    = clr ? 8'd0 : fp_r;
    pl_nxt    = clr ? 16'd0 : pl_r;
    src_nxt   = clr ? 128'd0 : src_r;
    dst_nxt   = clr ? 128'd0 : dst_r;
    sport_nxt = clr ? 16'd0 : sport_r;
    dport_nxt = clr ? 16'd0 : dport_r;
    crc_nxt   = clr ? CRC_INIT : crc_r;
    exp_nxt   = clr ? 32'd0 : exp_r;
    seen_nxt  = clr ? 1'b0 : seen_r;
    terr_nxt  = clr ? TE_NONE : terr_r;
    kind_nxt  = clr ? KIND_PLAIN : kind_r;
    phase_nxt = clr ? PH_RUN : phase_r;
    idx_nxt   = z;
    emit = 1'b0;
    full = 1'b0;
    st   = ST_PROXIED;
    hlen = z + 17'd1;
    o_init = clr;
    o_len  = 16'd0;
    o_step = 1'b0;
    i_init = clr;
    i_len  = 16'd0;
    i_step = 1'b0;
    off    = z - 17'd16;

    unique case (fp_nxt)
      FP_TCP4: fam = 2'd1;
      FP_TCP6: fam = 2'd2;
      default: fam = 2'd0;
    endcase
    alen = (fam == 2'd1) ? 5'd4 : ((fam == 2'd2) ? 5'd16 : 5'd0);
    flen = {alen, 1'b0} + 6'd4;

    if (process && phase_nxt == PH_RUN) begin
      if (z < IDX_MAX) idx_nxt = z + 17'd1;
      if (z < 17'd5 && b != sig1_byte(z[2:0])) sig_nxt = sig_nxt & 2'b10;
      if (z < 17'd12 && b != sig2_byte(z[3:0])) sig_nxt = sig_nxt & 2'b01;
      unique case (sig_nxt)
        2'b00: begin
          emit = 1'b1;
          st   = ST_JUNK;
        end
        2'b01: begin
          if (z >= 17'd5) begin
            if (z > {7'd0, v1_limit_r}) begin
              emit = 1'b1;
              st   = ST_OVERFLOW;
            end else if (b == 8'h0a) begin
              emit = 1'b1;
              st   = ST_V1_DONE;
            end
          end
        end
        2'b11: ;
        default: begin
          if (z == 17'd12) vc_nxt = b;
          else if (z == 17'd13) fp_nxt = b;
          else if (z == 17'd14) pl_nxt = {b, 8'd0};
          else if (z == 17'd15) pl_nxt = {pl_nxt[15:8], b};
          else if (z >= 17'd16 && alen != 5'd0 && pl_nxt >= {10'd0, flen}) begin
            if (off < {11'd0, flen}) begin
              if (off < {12'd0, alen}) src_nxt = {src_nxt[119:0], b};
              else if (off < {11'd0, alen, 1'b0}) dst_nxt = {dst_nxt[119:0], b};
              else if (off < {11'd0, alen, 1'b0} + 17'd2) sport_nxt = {sport_nxt[7:0], b};
              else dport_nxt = {dport_nxt[7:0], b};
              if (off == {11'd0, flen} - 17'd1) begin
                o_init = 1'b1;
                o_len  = pl_nxt - {10'd0, flen};
              end
            end else if (terr_nxt == TE_NONE) begin
              o_step = 1'b1;
              unique case (o_wo.res)
                WK_DRIBBLE: terr_nxt = TE_DRIBBLE;
                WK_LENGTH:  terr_nxt = TE_LENGTH;
                WK_HDR: begin
                  kind_nxt = KIND_PLAIN;
                  if (o_wo.hdr_type == TLV_TYPE_SSL) begin
                    if (o_wo.hdr_len < 16'd5) terr_nxt = TE_LENGTH;
                    else begin
                      kind_nxt = KIND_SSL;
                      i_init   = 1'b1;
                      i_len    = o_wo.hdr_len - 16'd5;
                    end
                  end else if (o_wo.hdr_type == TLV_TYPE_CRC && !seen_nxt) begin
                    if (o_wo.hdr_len < 16'd4) terr_nxt = TE_LENGTH;
                    else begin
                      kind_nxt = KIND_CRC;
                      seen_nxt = 1'b1;
                      exp_nxt  = 32'd0;
                    end
                  end
                end
                WK_VAL: begin
                  if (kind_nxt == KIND_CRC && o_wo.vidx < 16'd4) begin
                    exp_nxt = {exp_nxt[23:0], b};
                    cb      = 8'd0;
                  end else if (kind_nxt == KIND_SSL && o_wo.vidx >= 16'd5) begin
                    i_step = 1'b1;
                    if (i_wo.res == WK_DRIBBLE) terr_nxt = TE_DRIBBLE;
                    else if (i_wo.res == WK_LENGTH) terr_nxt = TE_LENGTH;
                  end
                end
                default: ;
              endcase
            end
          end
          crc_nxt = crc32c_byte(crc_nxt, cb);

          hlen = {1'b0, pl_nxt} + 17'd16;
          if (z == 17'd15 && pl_nxt > max_payload_r) begin
            emit = 1'b1;
            st   = ST_OVERFLOW;
            hlen = 17'd16;
          end else if ((z == 17'd15 && pl_nxt == 16'd0) ||
                       (z >= 17'd16 && z == {1'b0, pl_nxt} + 17'd15)) begin
            emit = 1'b1;
            // finish: version, command, family, then crc and walk errors
            if (vc_nxt[7:4] != 4'd2) st = ST_BAD_VER;
            else if (vc_nxt[3:0] == 4'd0) st = ST_LOCAL;
            else if (vc_nxt[3:0] != 4'd1) st = ST_BAD_CMD;
            else if (alen == 5'd0 || pl_nxt < {10'd0, flen}) st = ST_IGNORED;
            else begin
              full = 1'b1;
              if (seen_nxt && ~crc_nxt != exp_nxt) st = ST_CRC_ERR;
              else if (terr_nxt == TE_DRIBBLE) st = ST_DRIBBLE;
              else if (terr_nxt == TE_LENGTH) st = ST_LEN_ERR;
              else st = ST_PROXIED;
            end
          end
        end
      endcase
      if (emit) phase_nxt = PH_DONE;
    end else begin
      // hold everything when no byte is parsed
      phase_nxt = phase_r;
      idx_nxt   = idx_r;
      sig_nxt   = sig_r;
      vc_nxt    = vc_r;
      fp_nxt    = fp_r;
      pl_nxt    = pl_r;
      src_nxt   = src_r;
      dst_nxt   = dst_r;
      sport_nxt = sport_r;
      dport_nxt = dport_r;
      crc_nxt   = crc_r;
      exp_nxt   = exp_r;
      seen_nxt  = seen_r;
      terr_nxt  = terr_r;
      kind_nxt  = kind_r;
    end
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (process && emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      sig_r         <= 2'd3;
      max_payload_r <= MAX_PAYLOAD_RST;
      v1_limit_r    <= V1_LIMIT_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      sig_r       <= sig_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_PAYLOAD) max_payload_r <= cfg_data;
        else if (cfg_index == REG_V1_LIMIT) v1_limit_r <= cfg_data[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    idx_r   <= idx_nxt;
    vc_r    <= vc_nxt;
    fp_r    <= fp_nxt;
    pl_r    <= pl_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    sport_r <= sport_nxt;
    dport_r <= dport_nxt;
    crc_r   <= crc_nxt;
    exp_r   <= exp_nxt;
    seen_r  <= seen_nxt;
    terr_r  <= terr_nxt;
    kind_r  <= kind_nxt;
    if (process && emit) begin
      out_r.status        <= st;
      out_r.family        <= full ? fam : 2'd0;
      out_r.src_addr_hi   <= full ? src_nxt[127:64] : 64'd0;
      out_r.src_addr_lo   <= full ? src_nxt[63:0] : 64'd0;
      out_r.dst_addr_hi   <= full ? dst_nxt[127:64] : 64'd0;
      out_r.dst_addr_lo   <= full ? dst_nxt[63:0] : 64'd0;
      out_r.src_port      <= full ? sport_nxt : 16'd0;
      out_r.dst_port      <= full ? dport_nxt : 16'd0;
      out_r.tlv_length    <= full ? pl_nxt - {10'd0, flen} : 16'd0;
      out_r.header_length <= hlen;
    end
  end

  `PHV2_ASSERT(a_emit_lands, process && emit |=> out_valid_r, "result lost")
  `PHV2_ASSERT(a_stall_holds, in_valid_r && !advance |=> in_valid_r, "stalled byte dropped")
  `PHV2_ASSERT(a_run_sig, phase_r == PH_RUN |-> sig_r != 2'd0, "running with no signature")

endmodule

>>> dv/proxy_v2_header_parser_test.sv
// Self-checking testbench for the PROXY header parser: byte stream in, header results out.
`timescale 1ns / 1ps
module proxy_v2_header_parser_test;
  import phv2_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  proxy_v2_header_parser DUT (.*);

  always #2 clk = ~clk;

  typedef struct {
    logic [15:0] rem;
    logic [15:0] avail;
    logic [1:0] pos;
    logic [7:0] ttype;
    logic [1:0] kind;
    logic [15:0] tlen;
    logic [15:0] vpos;
  } walker_t;

  // predictor state
  logic [15:0] p_max_payload;
  logic [9:0] p_line_limit;
  logic [16:0] p_idx;
  logic [1:0] p_sig;
  logic [1:0] p_phase;
  logic [7:0] p_vc, p_fp;
  logic [15:0] p_plen;
  logic [63:0] p_addr [4];
  logic [15:0] p_port [2];
  walker_t p_outer, p_inner;
  logic [31:0] p_crc, p_exp_crc;
  logic p_crc_seen;
  logic [1:0] p_terr;

  in_item_t byte_queue [$];
  out_item_t header_queue [$];
  int errors = 0;
  bit stim_done = 0;
  int hold_cycles = 0;
  bit long_hold = 0;

  function automatic walker_t walker_clear(input logic [15:0] len);
    walker_t w;
    w = '{default: '0};
    w.rem = len;
    return w;
  endfunction

  // one TLV walk step; returns WK_* code, value index in vi
  function automatic logic [2:0] walker_step(inout walker_t w, input logic [7:0] b,
                                             output logic [15:0] vi);
    logic [2:0] r;
    r = WK_NONE;
    vi = '0;
    if (w.rem == 0) return WK_NONE;
    if (w.pos == 0) begin
      if (w.rem < 3) return WK_DRIBBLE;
      w.avail = w.rem;
      w.ttype = b;
      w.pos = 1;
    end else if (w.pos == 1) begin
      w.tlen = {b, 8'h00};
      w.pos = 2;
    end else if (w.pos == 2) begin
      w.tlen = w.tlen | {8'h00, b};
      if ({1'b0, w.tlen} + 17'd3 > {1'b0, w.avail}) return WK_LENGTH;
      w.vpos = 0;
      w.pos = (w.tlen != 0) ? 2'd3 : 2'd0;
      r = WK_HDR;
    end else begin
      vi = w.vpos;
      w.vpos++;
      if (w.vpos >= w.tlen) w.pos = 0;
      r = WK_VAL;
    end
    w.rem--;
    return r;
  endfunction

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = (c >> 1) ^ (32'h82F63B78 & {32{c[0]}});
    return c;
  endfunction

  function automatic logic [1:0] fam_of();
    if (p_fp == FP_TCP4) return 2'd1;
    if (p_fp == FP_TCP6) return 2'd2;
    return 2'd0;
  endfunction

  function automatic int addr_bytes();
    logic [1:0] f;
    f = fam_of();
    return f == 1 ? 4 : (f == 2 ? 16 : 0);
  endfunction

  task automatic push_header(input logic [3:0] st, input logic [16:0] hlen, input bit full);
    out_item_t o;
    o = '0;
    o.status = st;
    if (full) begin
      o.family = fam_of();
      o.src_addr_hi = p_addr[0];
      o.src_addr_lo = p_addr[1];
      o.dst_addr_hi = p_addr[2];
      o.dst_addr_lo = p_addr[3];
      o.src_port = p_port[0];
      o.dst_port = p_port[1];
      o.tlv_length = p_plen - 16'(2 * addr_bytes() + 4);
    end
    o.header_length = hlen;
    header_queue.push_back(o);
    p_phase = PH_DONE;
  endtask

  task automatic finish_header();
    logic [16:0] hlen;
    int al;
    hlen = {1'b0, p_plen} + 17'd16;
    al = addr_bytes();
    if (p_vc[7:4] != 4'd2) push_header(ST_BAD_VER, hlen, 0);
    else if (p_vc[3:0] == 0) push_header(ST_LOCAL, hlen, 0);
    else if (p_vc[3:0] != 1) push_header(ST_BAD_CMD, hlen, 0);
    else if (al == 0 || p_plen < 2 * al + 4) push_header(ST_IGNORED, hlen, 0);
    else if (p_crc_seen && ~p_crc != p_exp_crc) push_header(ST_CRC_ERR, hlen, 1);
    else if (p_terr == TE_DRIBBLE) push_header(ST_DRIBBLE, hlen, 1);
    else if (p_terr == TE_LENGTH) push_header(ST_LEN_ERR, hlen, 1);
    else push_header(ST_PROXIED, hlen, 1);
  endtask

  task automatic parser_clear();
    p_idx = 0; p_sig = 2'b11; p_vc = 0; p_fp = 0; p_plen = 0;
    for (int k = 0; k < 4; k++) p_addr[k] = 0;
    p_port[0] = 0; p_port[1] = 0;
    p_outer = walker_clear(0); p_inner = walker_clear(0);
    p_crc = CRC_INIT; p_exp_crc = 0; p_crc_seen = 0; p_terr = TE_NONE;
  endtask

  // payload byte handling; returns byte fed to CRC
  function automatic logic [7:0] payload_byte(input int off, input logic [7:0] b);
    int al, fl, k;
    logic [15:0] vi, vj;
    logic [2:0] r, r2;
    al = addr_bytes();
    fl = 2 * al + 4;
    if (al == 0 || p_plen < fl) return b;
    if (off < fl) begin
      k = off < al ? 0 : (off < 2 * al ? 2 : 4);
      if (k < 4) begin
        p_addr[k] = (p_addr[k] << 8) | (p_addr[k + 1] >> 56);
        p_addr[k + 1] = (p_addr[k + 1] << 8) | {56'd0, b};
      end else begin
        k = off < 2 * al + 2 ? 0 : 1;
        p_port[k] = {p_port[k][7:0], b};
      end
      if (off == fl - 1) p_outer = walker_clear(p_plen - 16'(fl));
      return b;
    end
    if (p_terr != TE_NONE) return b;
    r = walker_step(p_outer, b, vi);
    if (r == WK_DRIBBLE || r == WK_LENGTH) p_terr = r[1:0];
    else if (r == WK_HDR) begin
      p_outer.kind = KIND_PLAIN;
      if (p_outer.ttype == TLV_TYPE_SSL) begin
        if (p_outer.tlen < 5) p_terr = TE_LENGTH;
        else begin
          p_outer.kind = KIND_SSL;
          p_inner = walker_clear(p_outer.tlen - 16'd5);
        end
      end else if (p_outer.ttype == TLV_TYPE_CRC && !p_crc_seen) begin
        if (p_outer.tlen < 4) p_terr = TE_LENGTH;
        else begin
          p_outer.kind = KIND_CRC;
          p_crc_seen = 1;
          p_exp_crc = 0;
        end
      end
    end else if (r == WK_VAL) begin
      if (p_outer.kind == KIND_CRC && vi < 4) begin
        p_exp_crc = {p_exp_crc[23:0], b};
        return 8'h00;
      end
      if (p_outer.kind == KIND_SSL && vi >= 5) begin
        r2 = walker_step(p_inner, b, vj);
        if (r2 == WK_DRIBBLE || r2 == WK_LENGTH) p_terr = r2[1:0];
      end
    end
    return b;
  endfunction

  task automatic predict_byte(input in_item_t it);
    logic [16:0] z;
    logic [7:0] b, cb;
    b = it.data_byte;
    cb = b;
    if (it.first_byte) begin
      parser_clear();
      p_phase = PH_RUN;
    end
    if (p_phase != PH_RUN) return;
    z = p_idx;
    if (p_idx < IDX_MAX) p_idx++;
    if (z < 5 && b != sig1_at(z)) p_sig &= 2'b10;
    if (z < 12 && b != sig2_at(z)) p_sig &= 2'b01;
    if (p_sig == 0) begin push_header(ST_JUNK, z + 17'd1, 0); return; end
    if (p_sig == 1) begin
      if (z < 5) return;
      if (z > p_line_limit) push_header(ST_OVERFLOW, z + 17'd1, 0);
      else if (b == 8'h0a) push_header(ST_V1_DONE, z + 17'd1, 0);
      return;
    end
    if (p_sig == 3) return;
    if (z == 12) p_vc = b;
    else if (z == 13) p_fp = b;
    else if (z == 14) p_plen = {b, 8'h00};
    else if (z == 15) p_plen = p_plen | {8'h00, b};
    else if (z >= 16) cb = payload_byte(int'(z) - 16, b);
    p_crc = crc_update(p_crc, cb);
    if (z == 15) begin
      if (p_plen > p_max_payload) push_header(ST_OVERFLOW, 17'd16, 0);
      else if (p_plen == 0) finish_header();
    end else if (z >= 16 && z == 17'd15 + p_plen) finish_header();
  endtask

  function automatic logic [7:0] sig1_at(input logic [16:0] i);
    logic [7:0] s [5] = '{8'h50, 8'h52, 8'h4f, 8'h58, 8'h59};
    return s[i];
  endfunction

  function automatic logic [7:0] sig2_at(input logic [16:0] i);
    logic [7:0] s [12] = '{8'h0d, 8'h0a, 8'h0d, 8'h0a, 8'h00, 8'h0d, 8'h0a,
                           8'h51, 8'h55, 8'h49, 8'h54, 8'h0a};
    return s[i];
  endfunction

  // stimulus builders
  task automatic add_byte(input bit fb, input logic [7:0] b);
    in_item_t it;
    it.first_byte = fb;
    it.data_byte = b;
    byte_queue.push_back(it);
  endtask

  task automatic add_bytes(input logic [7:0] bs [$]);
    foreach (bs[i]) add_byte(i == 0, bs[i]);
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  // one v2 header; mode picks how the TLV region is shaped
  task automatic add_v2(input logic [7:0] vc, input logic [7:0] fp, input int tlv_mode);
    logic [7:0] body [$];
    logic [7:0] hdr [$];
    logic [7:0] tlv [$];
    logic [31:0] c;
    int al, n, crc_at, pl;
    al = fp == FP_TCP4 ? 4 : (fp == FP_TCP6 ? 16 : 0);
    if (al == 0) al = $urandom_range(0, 4);
    for (int i = 0; i < 2 * al + 4; i++) body.push_back(rnd_byte());
    crc_at = -1;
    case (tlv_mode)
      0: ;
      1: begin // plain TLVs, maybe an SSL one with sub-TLVs (some malformed), maybe a CRC TLV
        repeat ($urandom_range(0, 2)) begin
          n = $urandom_range(0, 6);
          tlv.push_back(8'($urandom_range(4, 255)) == TLV_TYPE_SSL ? 8'h05 : 8'h07);
          tlv.push_back(0); tlv.push_back(8'(n));
          repeat (n) tlv.push_back(rnd_byte());
        end
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(0, 2) * 4;
          tlv.push_back(TLV_TYPE_SSL); tlv.push_back(0); tlv.push_back(8'(5 + n));
          repeat (5) tlv.push_back(rnd_byte());
          if (n == 4) begin
            tlv.push_back(8'h22); tlv.push_back(0); tlv.push_back(1); tlv.push_back(rnd_byte());
          end else if (n == 8) begin
            tlv.push_back(8'h23); tlv.push_back(0); tlv.push_back(8'($urandom_range(4, 6)));
            repeat (5) tlv.push_back(rnd_byte());
          end
        end
        if ($urandom_range(0, 3) != 0) begin
          tlv.push_back(TLV_TYPE_CRC); tlv.push_back(0); tlv.push_back(4);
          crc_at = tlv.size();
          repeat (4) tlv.push_back(0);
          if ($urandom_range(0, 2) == 0) begin // second CRC TLV is plain
            tlv.push_back(TLV_TYPE_CRC); tlv.push_back(0); tlv.push_back(1);
            tlv.push_back(rnd_byte());
          end
        end
      end
      default: begin // random, often broken
        n = $urandom_range(0, 12);
        repeat (n) tlv.push_back($urandom_range(0, 2) == 0 ?
                                 ($urandom_range(0, 1) ? TLV_TYPE_CRC : TLV_TYPE_SSL) :
                                 8'($urandom_range(0, 9)));
      end
    endcase
    pl = body.size() + tlv.size();
    if (tlv_mode == 3) pl = $urandom_range(0, 1) ? 0 : $urandom_range(0, 40);
    hdr = '{8'h0d, 8'h0a, 8'h0d, 8'h0a, 8'h00, 8'h0d, 8'h0a, 8'h51, 8'h55, 8'h49,
            8'h54, 8'h0a};
    hdr.push_back(vc); hdr.push_back(fp);
    hdr.push_back(8'(pl >> 8)); hdr.push_back(8'(pl));
    foreach (body[i]) hdr.push_back(body[i]);
    foreach (tlv[i]) hdr.push_back(tlv[i]);
    while (hdr.size() > 16 + pl) void'(hdr.pop_back());
    while (hdr.size() < 16 + pl) hdr.push_back(rnd_byte());
    if (crc_at >= 0 && pl == body.size() + tlv.size() && $urandom_range(0, 4) != 0) begin
      c = CRC_INIT;
      foreach (hdr[i]) c = crc_update(c, hdr[i]);
      c = ~c;
      n = 16 + body.size() + crc_at;
      hdr[n] = c[31:24]; hdr[n + 1] = c[23:16]; hdr[n + 2] = c[15:8]; hdr[n + 3] = c[7:0];
    end
    add_bytes(hdr);
  endtask

  task automatic add_v1(input int len, input bit good);
    logic [7:0] bs [$];
    bs = '{8'h50, 8'h52, 8'h4f, 8'h58, 8'h59};
    if (!good) bs[$urandom_range(0, 4)] = rnd_byte();
    repeat (len) bs.push_back($urandom_range(0, 9) == 0 ? 8'h0d : 8'($urandom_range(32, 126)));
    bs.push_back(8'h0a);
    add_bytes(bs);
  endtask

  task automatic run_bytes();
    while (byte_queue.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    while (header_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_PAYLOAD) p_max_payload = val;
    else if (idx == REG_V1_LIMIT) p_line_limit = val[9:0];
  endtask

  task automatic random_traffic(input int count);
    int start, k;
    logic [7:0] vc;
    start = byte_queue.size();
    while (byte_queue.size() < count) begin
      k = $urandom_range(0, 19);
      vc = k == 0 ? rnd_byte() : (k == 1 ? 8'h20 : (k == 2 ? 8'h22 : 8'h21));
      if (k < 12) add_v2(vc, $urandom_range(0, 5) == 0 ? rnd_byte() :
                         ($urandom_range(0, 1) ? FP_TCP4 : FP_TCP6),
                         k < 8 ? 1 : (k < 10 ? 2 : (k == 10 ? 0 : 3)));
      else if (k < 15) add_v1($urandom_range(0, 30), k != 14);
      else if (k < 17) begin
        add_byte(1, rnd_byte());
        repeat ($urandom_range(0, 4)) add_byte($urandom_range(0, 3) == 0, rnd_byte());
      end else begin
        repeat ($urandom_range(1, 5)) add_byte(0, rnd_byte()); // ignored after done
        add_byte(1, 8'h0d);
        for (int i = 1; i < 12; i++) add_byte(0, i == 4 ? 8'h00 : rnd_byte());
      end
    end
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_byte(in_data);
        void'(byte_queue.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= byte_queue[0];
          if ($urandom_range(0, 3) == 0)
            gap <= $urandom_range(0, 19) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 2);
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (header_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, out_data);
        end else if (out_data !== header_queue[0]) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, header_queue[0], out_data);
          void'(header_queue.pop_front());
        end else void'(header_queue.pop_front());
      end
      if (long_hold) begin
        long_hold = 1'b0;
        hold_cycles <= 200;
        out_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= $urandom_range(0, 29) == 0 ? 1'b0 : ~out_ready;
        if ($urandom_range(0, 60) == 0) hold_cycles <= $urandom_range(5, 40);
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    p_max_payload = MAX_PAYLOAD_RST;
    p_line_limit = V1_LIMIT_RST;
    p_phase = PH_IDLE;
    parser_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray bytes, junk, v1, v2 extremes
    add_byte(0, 8'hff);
    add_byte(1, 8'h00);
    add_v1(3, 1);
    add_v1(120, 1);
    add_v2(8'h21, FP_TCP4, 1);
    add_v2(8'h21, FP_TCP6, 1);
    add_v2(8'h20, FP_TCP4, 0);
    add_v2(8'h31, FP_TCP4, 0);
    add_v2(8'h2f, FP_TCP6, 0);
    add_v2(8'h21, 8'hff, 0);
    add_v2(8'h21, FP_TCP4, 3);
    add_v2(8'h21, FP_TCP6, 2);
    run_bytes();
    drain();

    // long receiver stall while the sender keeps offering
    @(posedge clk);
    long_hold = 1'b1;
    random_traffic(200);
    run_bytes();
    drain();

    write_reg(REG_MAX_PAYLOAD, 16'd0);
    write_reg(REG_V1_LIMIT, 16'd0);
    random_traffic(100);
    run_bytes();
    drain();

    write_reg(REG_MAX_PAYLOAD, 16'hffff);
    write_reg(REG_V1_LIMIT, 16'd1023);
    random_traffic(300);
    run_bytes();
    drain();

    write_reg(REG_MAX_PAYLOAD, 16'd30);
    write_reg(REG_V1_LIMIT, 16'd5);
    random_traffic(150);
    run_bytes();
    drain();

    write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
    write_reg(REG_V1_LIMIT, 16'd20);
    random_traffic(300);
    run_bytes();
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && header_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
